/* src/lpbm_pkg.sv */
// Shared types and constants for the LRU page buffer manager.
// No dependencies.
`default_nettype none
package lpbm_pkg;
   localparam int FRAMES       = 64;
   localparam int FRAME_BITS   = $clog2(FRAMES);
   localparam int PAGE_ID_BITS = 20;
   localparam int FIX_BITS     = 16;
   localparam int TOTAL_BITS   = 32;
   localparam int FRAME_OUT_BITS = 6;

   localparam logic FUNC_FIX   = 1'b0;
   localparam logic FUNC_UNFIX = 1'b1;

   typedef enum logic [3:0] {
      CMD_NONE,
      CMD_START,
      CMD_SCAN,
      CMD_TAKE_HIT,
      CMD_TAKE_NEW,
      CMD_SET_ERR,
      CMD_FIX_WR,
      CMD_UNFIX_WR,
      CMD_VIC_RD,
      CMD_TAKE_VIC,
      CMD_VIC_WB,
      CMD_INSTALL,
      CMD_ROT_INIT,
      CMD_ROT_RD,
      CMD_ROT_WR,
      CMD_OUT
   } cmd_type;

   typedef struct packed {
      logic func;
      logic match;
      logic scan_last;
      logic used_full;
      logic rot_stop;
   } stat_type;
endpackage
`default_nettype wire

/* src/lpbm_ctrl.sv */
// Request sequencer for the page buffer manager.
// Depends on lpbm_pkg; drives the datapath by commands.
`default_nettype none
module lpbm_ctrl
   import lpbm_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_tvalid,
   output logic          req_tready,
   output logic          rsp_tvalid,
   input  wire logic     rsp_tready,
   input  wire stat_type stat,
   output cmd_type       cmd
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_PRIME, ST_SCAN, ST_CNT_RD, ST_CNT_WR, ST_VRD, ST_VTAKE, ST_VWB,
      ST_INSTALL, ST_ROT_INIT, ST_ROT_RD, ST_ROT_WR, ST_RESP
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      unique case (state_ff)
         ST_IDLE: if (req_tvalid) begin
            cmd      = CMD_START;
            state_in = ST_PRIME;
         end
         ST_PRIME: begin
            cmd      = CMD_SCAN;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (stat.match) begin
               cmd      = CMD_TAKE_HIT;
               state_in = ST_CNT_RD;
            end else if (stat.scan_last) begin
               if (stat.func == FUNC_UNFIX) begin
                  cmd      = CMD_SET_ERR;
                  state_in = ST_RESP;
               end else if (stat.used_full) begin
                  state_in = ST_VRD;
               end else begin
                  cmd      = CMD_TAKE_NEW;
                  state_in = ST_INSTALL;
               end
            end else begin
               cmd = CMD_SCAN;
            end
         end
         ST_CNT_RD: state_in = ST_CNT_WR;
         ST_CNT_WR: begin
            if (stat.func == FUNC_UNFIX) begin
               cmd      = CMD_UNFIX_WR;
               state_in = ST_RESP;
            end else begin
               cmd      = CMD_FIX_WR;
               state_in = ST_ROT_INIT;
            end
         end
         ST_VRD: begin
            cmd      = CMD_VIC_RD;
            state_in = ST_VTAKE;
         end
         ST_VTAKE: begin
            cmd      = CMD_TAKE_VIC;
            state_in = ST_VWB;
         end
         ST_VWB: begin
            cmd      = CMD_VIC_WB;
            state_in = ST_INSTALL;
         end
         ST_INSTALL: begin
            cmd      = CMD_INSTALL;
            state_in = ST_ROT_INIT;
         end
         ST_ROT_INIT: begin
            cmd      = CMD_ROT_INIT;
            state_in = ST_ROT_RD;
         end
         ST_ROT_RD: begin
            cmd      = CMD_ROT_RD;
            state_in = ST_ROT_WR;
         end
         ST_ROT_WR: begin
            cmd      = CMD_ROT_WR;
            state_in = stat.rot_stop ? ST_RESP : ST_ROT_RD;
         end
         ST_RESP: if (!rsp_valid_ff || rsp_tready) begin
            cmd      = CMD_OUT;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd == CMD_OUT)
            rsp_valid_ff <= 1'b1;
         else if (rsp_tready)
            rsp_valid_ff <= 1'b0;
      end
   end
endmodule
`default_nettype wire

/* src/lpbm_dpath.sv */
// Frame tables, recency list, fix counts and result register.
// Depends on lpbm_pkg; sequenced by lpbm_ctrl.
`default_nettype none
module lpbm_dpath
   import lpbm_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cmd_type                   cmd,
   input  wire logic                      req_func,
   input  wire logic [PAGE_ID_BITS-1:0]   req_page,
   input  wire logic                      req_wi,
   output stat_type                       stat,
   output logic [FRAME_OUT_BITS-1:0]      out_frame,
   output logic                           out_hit,
   output logic                           out_load,
   output logic                           out_wb,
   output logic [PAGE_ID_BITS-1:0]        out_evp,
   output logic                           out_status
);
   localparam logic [FRAME_BITS-1:0] LAST = FRAME_BITS'(FRAMES - 1);

   logic [PAGE_ID_BITS-1:0] page_mem [FRAMES];
   logic [FRAME_BITS-1:0]   ord_mem  [FRAMES];
   logic [FIX_BITS-1:0]     cnt_mem  [FRAMES];

   logic [FRAMES-1:0]       valid_ff, dirty_ff;
   logic [FRAME_BITS:0]     used_ff;
   logic [TOTAL_BITS-1:0]   hit_total_ff, miss_total_ff;

   logic                    func_ff, wi_ff;
   logic [PAGE_ID_BITS-1:0] pid_ff;
   logic [FRAME_BITS-1:0]   sa_ff, sidx_ff, f_ff, pos_ff, ri_ff, carry_ff;
   logic                    cmp_ff, pv_ff;
   logic [PAGE_ID_BITS-1:0] page_q_ff;
   logic [FRAME_BITS-1:0]   ord_q_ff;
   logic [FIX_BITS-1:0]     cnt_q_ff;
   logic                    hit_ff, load_ff, wb_ff, status_ff;
   logic [PAGE_ID_BITS-1:0] evp_ff;

   logic [FRAME_BITS-1:0]   page_ra, ord_ra;

   assign page_ra = (cmd == CMD_TAKE_VIC) ? ord_q_ff : sa_ff;
   assign ord_ra  = (cmd == CMD_VIC_RD) ? LAST : ri_ff;

   assign stat.func      = func_ff;
   assign stat.match     = pv_ff && (page_q_ff == pid_ff);
   assign stat.scan_last = (sidx_ff == LAST);
   assign stat.used_full = (used_ff == (FRAME_BITS+1)'(FRAMES));
   assign stat.rot_stop  = (cmp_ff && (ord_q_ff == f_ff)) || (ri_ff == pos_ff);

   always_ff @(posedge clock) begin
      page_q_ff <= page_mem[page_ra];
      pv_ff     <= valid_ff[page_ra];
      if (cmd == CMD_INSTALL)
         page_mem[f_ff] <= pid_ff;
   end

   always_ff @(posedge clock) begin
      ord_q_ff <= ord_mem[ord_ra];
      if (cmd == CMD_ROT_WR)
         ord_mem[ri_ff] <= carry_ff;
   end

   always_ff @(posedge clock) begin
      cnt_q_ff <= cnt_mem[f_ff];
      case (cmd)
         CMD_INSTALL:  cnt_mem[f_ff] <= FIX_BITS'(1);
         CMD_FIX_WR:   cnt_mem[f_ff] <= (cnt_q_ff == '1) ? cnt_q_ff : cnt_q_ff + 1'b1;
         CMD_UNFIX_WR: cnt_mem[f_ff] <= (cnt_q_ff == '0) ? cnt_q_ff : cnt_q_ff - 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         dirty_ff      <= '0;
         used_ff       <= '0;
         hit_total_ff  <= '0;
         miss_total_ff <= '0;
      end else begin
         if (cmd == CMD_INSTALL) begin
            valid_ff[f_ff] <= 1'b1;
            dirty_ff[f_ff] <= wi_ff;
            miss_total_ff  <= miss_total_ff + 1'b1;
            if (!stat.used_full)
               used_ff <= used_ff + 1'b1;
         end
         if (cmd == CMD_FIX_WR)
            hit_total_ff <= hit_total_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd)
         CMD_START: begin
            func_ff   <= req_func;
            pid_ff    <= req_page;
            wi_ff     <= req_wi;
            sa_ff     <= '0;
            f_ff      <= '0;
            hit_ff    <= 1'b0;
            load_ff   <= 1'b0;
            wb_ff     <= 1'b0;
            evp_ff    <= '0;
            status_ff <= 1'b0;
         end
         CMD_SCAN: begin
            sidx_ff <= sa_ff;
            sa_ff   <= sa_ff + 1'b1;
         end
         CMD_TAKE_HIT: begin
            f_ff   <= sidx_ff;
            hit_ff <= 1'b1;
            cmp_ff <= 1'b1;
            pos_ff <= LAST;
         end
         CMD_TAKE_NEW: begin
            f_ff    <= used_ff[FRAME_BITS-1:0];
            pos_ff  <= used_ff[FRAME_BITS-1:0];
            cmp_ff  <= 1'b0;
            load_ff <= 1'b1;
         end
         CMD_SET_ERR: status_ff <= 1'b1;
         CMD_TAKE_VIC: begin
            f_ff    <= ord_q_ff;
            pos_ff  <= LAST;
            cmp_ff  <= 1'b0;
            load_ff <= 1'b1;
         end
         CMD_VIC_WB: if (valid_ff[f_ff] && dirty_ff[f_ff]) begin
            wb_ff  <= 1'b1;
            evp_ff <= page_q_ff;
         end
         CMD_ROT_INIT: begin
            ri_ff    <= '0;
            carry_ff <= f_ff;
         end
         CMD_ROT_WR: begin
            carry_ff <= ord_q_ff;
            ri_ff    <= ri_ff + 1'b1;
         end
         CMD_OUT: begin
            out_frame  <= FRAME_OUT_BITS'(f_ff);
            out_hit    <= hit_ff;
            out_load   <= load_ff;
            out_wb     <= wb_ff;
            out_evp    <= evp_ff;
            out_status <= status_ff;
         end
         default: ;
      endcase
   end
endmodule
`default_nettype wire

/* src/lru_page_buffer_manager_core.sv */
// Top level of the LRU page buffer manager.
// Depends on lpbm_pkg, lpbm_ctrl and lpbm_dpath.
`default_nettype none
// One request at a time. A request scans the 64 frame tags one per cycle
// (stopping at a hit), then a fix walks the recency list, with a read and
// a write state per position, up to the touched frame. The scan of the tag
// memory and the walk of the recency memory set how long a request takes.
// The result waits in an output register; the next request is taken once
// it is queued.
module lru_page_buffer_manager_core
   import lpbm_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,  // page_id[19:0], write_intent[20], zeros
   input  wire logic        req_tuser,  // func
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata   // frame[5:0], hit, load_needed, writeback,
                                        // evicted_page[28:9], status[29], zeros
);
   cmd_type  cmd;
   stat_type stat;
   logic [FRAME_OUT_BITS-1:0] frame;
   logic                      hit, load, wb, status;
   logic [PAGE_ID_BITS-1:0]   evp;

   lpbm_ctrl u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .rsp_tvalid, .rsp_tready,
      .stat, .cmd
   );

   lpbm_dpath u_dpath (
      .clock, .reset, .cmd,
      .req_func  (req_tuser),
      .req_page  (req_tdata[PAGE_ID_BITS-1:0]),
      .req_wi    (req_tdata[PAGE_ID_BITS]),
      .stat,
      .out_frame (frame),
      .out_hit   (hit),
      .out_load  (load),
      .out_wb    (wb),
      .out_evp   (evp),
      .out_status(status)
   );

   assign rsp_tdata = {2'b00, status, evp, wb, load, hit, frame};

   a_wb_needs_load: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && wb |-> load) else $error("writeback without load");
   a_hit_not_load: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && hit |-> !load && !status) else $error("hit with load or error");
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && status |-> frame == '0 && !load) else $error("error result not clean");
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready) else $error("second request taken");
endmodule
`default_nettype wire

/* tb/lru_page_buffer_manager_core_tb.sv */
// Testbench for the LRU page buffer manager core: fix and unfix requests are
// predicted by a behavioral copy of the frame table and checked per result.
// Depends on lpbm_pkg and lru_page_buffer_manager_core.
`default_nettype none
module lru_page_buffer_manager_core_tb
   import lpbm_pkg::*;
();

   // first member lands in the top bits, so frame is listed last
   typedef struct packed {
      logic        status;
      logic [19:0] evicted_page;
      logic        writeback;
      logic        load_needed;
      logic        hit;
      logic [5:0]  frame;
   } page_result_type;

   localparam int EXP_DEPTH = 1024;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [23:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;

   lru_page_buffer_manager_core u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial forever #5 clock = ~clock;

   // frame table copy
   logic        pv_valid [FRAMES];
   logic [19:0] pv_page  [FRAMES];
   logic [15:0] pv_fix   [FRAMES];
   logic        pv_dirty [FRAMES];
   int          pv_order [FRAMES];
   int          pv_used;
   int unsigned pv_hits, pv_misses;

   // expected results, written at request accept, read at result accept
   page_result_type exp_mem [EXP_DEPTH];
   int  exp_wr = 0, exp_rd = 0;
   int  errors = 0;
   int  n_sent = 0, n_checked = 0;
   int  send_idle_pct = 0, recv_stall_pct = 0;
   bit  hold_off = 1'b0;
   int  quiet = 0;

   function automatic page_result_type predict_page(logic func, logic [19:0] pid, logic wi);
      page_result_type r;
      int f, p, v;
      r = '0;
      f = FRAMES;
      for (int i = 0; i < FRAMES; i++)
         if (f == FRAMES && pv_valid[i] && pv_page[i] == pid) f = i;
      if (func == FUNC_UNFIX) begin
         if (f < FRAMES) begin
            if (pv_fix[f] > 0) pv_fix[f]--;
            r.frame = 6'(f); r.hit = 1'b1;
         end else r.status = 1'b1;
      end else if (f < FRAMES) begin
         pv_hits++;
         if (pv_fix[f] != 16'hFFFF) pv_fix[f]++;
         p = 0;
         for (int i = 0; i < pv_used; i++) if (pv_order[i] == f) p = i;
         for (int i = p; i > 0; i--) pv_order[i] = pv_order[i-1];
         pv_order[0] = f;
         r.frame = 6'(f); r.hit = 1'b1;
      end else begin
         pv_misses++;
         if (pv_used < FRAMES) begin
            f = pv_used;
            for (int i = pv_used; i > 0; i--) pv_order[i] = pv_order[i-1];
            pv_order[0] = f;
            pv_used++;
         end else begin
            v = pv_order[FRAMES-1];
            f = v;
            if (pv_valid[f] && pv_dirty[f]) begin
               r.writeback = 1'b1; r.evicted_page = pv_page[f];
            end
            for (int i = FRAMES-1; i > 0; i--) pv_order[i] = pv_order[i-1];
            pv_order[0] = v;
         end
         pv_valid[f] = 1'b1; pv_page[f] = pid; pv_fix[f] = 16'd1; pv_dirty[f] = wi;
         r.frame = 6'(f); r.load_needed = 1'b1;
      end
      return r;
   endfunction

   // req_tvalid stays high after an accept; the next call replaces or drops it, wait_drained drops it
   task automatic send_request(logic func, logic [19:0] pid, logic wi);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {3'b000, wi, pid};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      exp_mem[exp_wr % EXP_DEPTH] = predict_page(func, pid, wi);
      exp_wr++;
      n_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (exp_wr != exp_rd) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // receiver
   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      page_result_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[29:0];
         if (exp_wr == exp_rd) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
         end else begin
            want = exp_mem[exp_rd % EXP_DEPTH];
            exp_rd++;
            n_checked++;
            if (got.frame !== want.frame)
               $display("%0t: frame expected %0d actual %0d", $time, want.frame, got.frame);
            if (got.hit !== want.hit)
               $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
            if (got.load_needed !== want.load_needed)
               $display("%0t: load expected %b actual %b", $time, want.load_needed,
                        got.load_needed);
            if (got.writeback !== want.writeback)
               $display("%0t: writeback expected %b actual %b", $time, want.writeback,
                        got.writeback);
            if (got.evicted_page !== want.evicted_page)
               $display("%0t: evicted_page expected %h actual %h", $time,
                        want.evicted_page, got.evicted_page);
            if (got.status !== want.status)
               $display("%0t: status expected %b actual %b", $time, want.status, got.status);
            if (got !== want) errors++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset ||
          (exp_wr == exp_rd && !req_tvalid)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet > 20000) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic test_directed();
      send_request(FUNC_UNFIX, 20'h00000, 1'b0);      // unfix, nothing resident
      send_request(FUNC_FIX, 20'h00000, 1'b1);
      send_request(FUNC_FIX, 20'hFFFFF, 1'b0);
      send_request(FUNC_FIX, 20'h00000, 1'b0);        // hit keeps dirty
      send_request(FUNC_UNFIX, 20'h00000, 1'b0);
      send_request(FUNC_UNFIX, 20'h00000, 1'b0);
      send_request(FUNC_UNFIX, 20'h00000, 1'b0);      // count at zero
      send_request(FUNC_UNFIX, 20'hFFFFF, 1'b1);
      send_request(FUNC_UNFIX, 20'h12345, 1'b1);
      wait_drained();
   endtask

   task automatic test_fill_and_evict();
      // fill all frames, then force evictions of dirty and clean victims
      for (int i = 0; i < FRAMES + 8; i++)
         send_request(FUNC_FIX, 20'(20'h80000 + i), i[0]);
      wait_drained();
   endtask

   task automatic test_random(int n);
      logic [19:0] pid;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0: pid = 20'($urandom());                     // noise across full range
            1, 2: pid = 20'(20'h80000 + $urandom_range(FRAMES + 8));
            default: pid = 20'($urandom_range(95));       // working set near buffer size
         endcase
         send_request(($urandom_range(3) == 0) ? FUNC_UNFIX : FUNC_FIX, pid,
                      1'($urandom_range(1)));
      end
      wait_drained();
   endtask

   task automatic test_backpressure();
      hold_off = 1'b1;
      fork
         begin repeat (1500) @(posedge clock); hold_off = 1'b0; end
         for (int i = 0; i < 12; i++)
            send_request(FUNC_FIX, 20'($urandom_range(40)), 1'b1);
      join
      wait_drained();   // sender pauses until all results came back
   endtask

   initial begin
      for (int i = 0; i < FRAMES; i++) begin
         pv_valid[i] = 0; pv_page[i] = 0; pv_fix[i] = 0; pv_dirty[i] = 0; pv_order[i] = 0;
      end
      pv_used = 0; pv_hits = 0; pv_misses = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_fill_and_evict();
      test_random(150);
      send_idle_pct = 68; test_random(120);
      send_idle_pct = 0; recv_stall_pct = 68; test_random(120);
      send_idle_pct = 14; recv_stall_pct = 14; test_random(120);
      send_idle_pct = 0; recv_stall_pct = 0;
      test_backpressure();
      repeat (50) @(posedge clock);
      $display("Covered %0d requests (%0d fix hits, %0d fix misses), %0d results checked,",
               n_sent, pv_hits, pv_misses, n_checked);
      $display("with fills, evictions, unfix errors, idle and stall phases.");
      if (errors == 0 && exp_wr == exp_rd) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end
endmodule
`default_nettype wire
